### rtl/b64lw_pkg.sv
package b64lw_pkg;

    // Field widths of the external payload.
    localparam int unsigned ByteW = 8;
    localparam int unsigned CodeW = 6;

    // Reset value of the line length register and floor of the line length in use.
    localparam logic [ByteW-1:0] LineLengthReset = 8'd76;
    localparam logic [ByteW-1:0] LineLengthMin   = 8'd4;

    // Depth of the symbol queue between front and back.
    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

    // Fixed output characters.
    localparam logic [ByteW-1:0] CharCr  = 8'h0d;
    localparam logic [ByteW-1:0] CharLf  = 8'h0a;
    localparam logic [ByteW-1:0] CharPad = 8'h3d;

    // Input transaction.
    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             last_byte;
    } t_in_item;

    // Output transaction.
    typedef struct packed {
        logic [ByteW-1:0] out_char;
        logic             last_char;
        logic             end_of_message;
    } t_out_item;

    // One symbol handed from the front to the back: a 6-bit group or a pad.
    typedef struct packed {
        logic [CodeW-1:0] code;
        logic             pad;
        logic             item_end;
        logic             msg_end;
    } t_sym;

    // Standard Base64 alphabet.
    function automatic logic [ByteW-1:0] b64_char(input logic [CodeW-1:0] code);
        logic [ByteW-1:0] c;
        c = {2'b00, code};
        if (code < 6'd26) begin
            b64_char = 8'h41 + c;
        end else if (code < 6'd52) begin
            b64_char = 8'h61 + c - 8'd26;
        end else if (code < 6'd62) begin
            b64_char = 8'h30 + c - 8'd52;
        end else if (code == 6'd62) begin
            b64_char = 8'h2b;
        end else begin
            b64_char = 8'h2f;
        end
    endfunction

endpackage

### rtl/base64_line_wrapped_encoder_core.sv
// A byte is registered in the front's bit store, its symbols pass through the symbol
// queue, and each character is registered in the output register.
// Throughput: one output character per cycle at the output register while the consumer
// pops, CR and LF included; the front splits a byte into one to four symbols at one per
// cycle while the symbol queue has room.
// Reset (synchronous, active low) empties the queue and output, clears the encoder
// control state (not the data stores) and sets the line length to 76.
module base64_line_wrapped_encoder_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  b64lw_pkg::t_in_item  i_data,
    output logic                 empty,
    input  logic                 pop,
    output b64lw_pkg::t_out_item o_data,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_data
);

    logic [7:0]      r_line_len;
    logic            sym_push;
    b64lw_pkg::t_sym sym_in;
    b64lw_pkg::t_sym sym_out;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;

    // Line length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_len <= b64lw_pkg::LineLengthReset;
        end else if (i_cfg_we) begin
            r_line_len <= i_cfg_data;
        end
    end

    b64lw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_item     (i_data),
        .i_q_full   (q_full),
        .o_sym_push (sym_push),
        .o_sym      (sym_in)
    );

    b64lw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (sym_push),
        .i_sym   (sym_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_sym   (sym_out)
    );

    b64lw_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_line_length (r_line_len),
        .i_q_empty     (q_empty),
        .i_sym         (sym_out),
        .o_q_pop       (q_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_item        (o_data)
    );

endmodule

### rtl/b64lw_front.sv
module b64lw_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  b64lw_pkg::t_in_item i_item,
    input  logic                i_q_full,
    output logic                o_sym_push,
    output b64lw_pkg::t_sym     o_sym
);

    // Bit store: leftover bits sit in the low end, the new byte is shifted in.
    logic        r_busy;
    logic [11:0] r_store;
    logic [3:0]  r_bits;
    logic [1:0]  r_phase;
    logic        r_last;

    logic        has_data;
    logic        flush;
    logic [3:0]  shift;
    logic [11:0] shifted;
    logic [5:0]  code;
    logic [3:0]  n_bits;
    logic [1:0]  n_phase;
    logic        final_sym;
    logic        accept;
    logic [3:0]  base_bits;
    logic [1:0]  base_phase;

    // Pick the next symbol: a full group, the zero-filled leftover, or a pad.
    always_comb begin
        has_data = (r_bits >= 4'd6);
        flush    = r_last && !has_data && (r_bits != 4'd0);
        shift    = r_bits - 4'd6;
        shifted  = r_store >> shift;
        if (has_data) begin
            code   = shifted[5:0];
            n_bits = r_bits - 4'd6;
        end else if (flush) begin
            code   = (r_bits == 4'd4) ? {r_store[3:0], 2'b00} : {r_store[1:0], 4'b0000};
            n_bits = 4'd0;
        end else begin
            code   = 6'd0;
            n_bits = r_bits;
        end
        n_phase   = r_phase + 2'd1;
        final_sym = (n_bits < 4'd6) && (!r_last || (n_bits == 4'd0 && n_phase == 2'd0));
    end

    // Queue side: one symbol per cycle while the queue has room.
    assign o_sym_push     = r_busy && !i_q_full;
    assign o_sym.code     = code;
    assign o_sym.pad      = !has_data && !flush;
    assign o_sym.item_end = final_sym;
    assign o_sym.msg_end  = final_sym && r_last;

    // A new transaction is taken when idle or as the last symbol leaves.
    assign o_full     = r_busy && !(o_sym_push && final_sym);
    assign accept     = i_push && !o_full;
    assign base_bits  = o_sym_push ? n_bits : r_bits;
    assign base_phase = o_sym_push ? n_phase : r_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_bits  <= 4'd0;
            r_phase <= 2'd0;
            r_last  <= 1'b0;
        end else begin
            if (accept) begin
                r_busy  <= 1'b1;
                r_store <= {r_store[3:0], i_item.data_byte};
                r_bits  <= base_bits + 4'd8;
                r_phase <= base_phase;
                r_last  <= i_item.last_byte;
            end else if (o_sym_push) begin
                r_busy  <= !final_sym;
                r_bits  <= n_bits;
                r_phase <= n_phase;
            end
        end
    end

endmodule

### rtl/b64lw_queue.sv
module b64lw_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  b64lw_pkg::t_sym i_sym,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output b64lw_pkg::t_sym o_sym
);

    localparam int unsigned PtrW = b64lw_pkg::QueuePtrW;
    localparam int unsigned CntW = b64lw_pkg::QueuePtrW + 1;

    b64lw_pkg::t_sym r_mem [b64lw_pkg::QueueDepth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CntW'(b64lw_pkg::QueueDepth));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_sym   = r_mem[r_rd_ptr];

    // Storage needs no reset; only pointers and count are cleared.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_sym;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PtrW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PtrW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CntW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

endmodule

### rtl/b64lw_back.sv
module b64lw_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_line_length,
    input  logic                 i_q_empty,
    input  b64lw_pkg::t_sym      i_sym,
    output logic                 o_q_pop,
    output logic                 o_empty,
    input  logic                 i_pop,
    output b64lw_pkg::t_out_item o_item
);

    typedef enum logic [1:0] {
        S_CHAR,
        S_CR,
        S_LF
    } t_state;

    t_state               r_state,     n_state;
    logic [7:0]           r_column,    n_column;
    logic                 r_valid,     n_valid;
    b64lw_pkg::t_out_item r_out,       n_out;
    logic                 r_pend_last, n_pend_last;
    logic                 r_pend_eom,  n_pend_eom;

    logic       load_ok;
    logic [7:0] limit;
    logic [7:0] col_inc;
    logic       wrap;

    // The output register can take a new character when empty or being drained.
    assign load_ok = !r_valid || i_pop;
    assign limit   = (i_line_length < b64lw_pkg::LineLengthMin) ?
                     b64lw_pkg::LineLengthMin : i_line_length;
    assign col_inc = r_column + 8'd1;
    assign wrap    = (col_inc >= limit);
    assign o_q_pop = (r_state == S_CHAR) && !i_q_empty && load_ok;
    assign o_empty = !r_valid;
    assign o_item  = r_out;

    // Emit one character per cycle while the output register can take it; a full line is followed by CR and LF.
    always_comb begin
        n_state     = r_state;
        n_column    = r_column;
        n_out       = r_out;
        n_pend_last = r_pend_last;
        n_pend_eom  = r_pend_eom;
        n_valid     = r_valid && !i_pop;
        unique case (r_state)
            S_CHAR: begin
                if (o_q_pop) begin
                    n_valid              = 1'b1;
                    n_out.out_char       = i_sym.pad ? b64lw_pkg::CharPad :
                                           b64lw_pkg::b64_char(i_sym.code);
                    n_out.last_char      = i_sym.item_end && !wrap;
                    n_out.end_of_message = i_sym.msg_end && !wrap;
                    n_pend_last          = i_sym.item_end;
                    n_pend_eom           = i_sym.msg_end;
                    n_column             = (wrap || i_sym.msg_end) ? 8'd0 : col_inc;
                    n_state              = wrap ? S_CR : S_CHAR;
                end
            end
            S_CR: begin
                if (load_ok) begin
                    n_valid              = 1'b1;
                    n_out.out_char       = b64lw_pkg::CharCr;
                    n_out.last_char      = 1'b0;
                    n_out.end_of_message = 1'b0;
                    n_state              = S_LF;
                end
            end
            S_LF: begin
                if (load_ok) begin
                    n_valid              = 1'b1;
                    n_out.out_char       = b64lw_pkg::CharLf;
                    n_out.last_char      = r_pend_last;
                    n_out.end_of_message = r_pend_eom;
                    n_state              = S_CHAR;
                end
            end
            default: begin
                n_state = S_CHAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CHAR;
            r_column    <= 8'd0;
            r_valid     <= 1'b0;
            r_pend_last <= 1'b0;
            r_pend_eom  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_column    <= n_column;
            r_valid     <= n_valid;
            r_pend_last <= n_pend_last;
            r_pend_eom  <= n_pend_eom;
        end
        r_out <= n_out;
    end

endmodule
